### rtl/hwbt_pkg.sv
// ----------------------------------------------------------------------------
// hwbt_pkg - shared types and constants for the HTML word/block tokenizer
// Byte classes, event records, scan codes and tokenizer defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package hwbt_pkg;

   localparam int OFFSET_BITS_DEF = 24;
   localparam int NAME_BYTES_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int SPAN_BITS       = 24;

   // all five characters of the preamble marker matched
   localparam logic [2:0] PRE_DONE = 3'd5;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_C     = 8'h63;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_BREAK = 2'd1,
      KIND_IMAGE = 2'd2,
      KIND_ERROR = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      MODE_GAP  = 2'd0,
      MODE_WORD = 2'd1,
      MODE_TAG  = 2'd2
   } scan_mode_type;

   // progress of the src attribute search inside a tag
   typedef enum logic [2:0] {
      SRC_IDLE  = 3'd0,
      SRC_S     = 3'd1,
      SRC_R     = 3'd2,
      SRC_C     = 3'd3,
      SRC_SEP   = 3'd4,
      SRC_VALUE = 3'd5,
      SRC_FOUND = 3'd6
   } src_phase_type;

   typedef struct packed {
      logic first;
      logic close;
      logic slash;
      logic name_end;
      logic too_long;
   } tag_flags_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_ws;
      logic       is_space;
      logic       is_lt;
      logic       is_gt;
      logic       is_slash;
      logic       is_quote;
      logic       is_s;
      logic       is_r;
      logic       is_c;
   } byte_class_type;

   typedef struct packed {
      event_kind_type         kind;
      logic [SPAN_BITS-1:0]   span_start;
      logic [SPAN_BITS-1:0]   span_end;
      logic                   bold_on;
      logic                   italic_on;
   } event_type;

   // characters of "<html" by position
   function automatic logic [7:0] preamble_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = CH_LT;
         3'd1:    ch = 8'h68;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h6D;
         3'd4:    ch = 8'h6C;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/hwbt_classify.sv
// ----------------------------------------------------------------------------
// hwbt_classify - input byte classifier
// Decodes the character classes the scanner needs from one document byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hwbt_classify (
   input  wire logic [7:0]              data_byte,
   input  wire logic                    last_byte,
   output hwbt_pkg::byte_class_type     cls
);

   assign cls.data     = data_byte;
   assign cls.last     = last_byte;
   assign cls.is_ws    = (data_byte == hwbt_pkg::CH_SPACE) || (data_byte == hwbt_pkg::CH_TAB) ||
                         (data_byte == hwbt_pkg::CH_LF)    || (data_byte == hwbt_pkg::CH_CR);
   assign cls.is_space = (data_byte == hwbt_pkg::CH_SPACE);
   assign cls.is_lt    = (data_byte == hwbt_pkg::CH_LT);
   assign cls.is_gt    = (data_byte == hwbt_pkg::CH_GT);
   assign cls.is_slash = (data_byte == hwbt_pkg::CH_SLASH);
   assign cls.is_quote = (data_byte == hwbt_pkg::CH_QUOTE);
   assign cls.is_s     = (data_byte == hwbt_pkg::CH_S);
   assign cls.is_r     = (data_byte == hwbt_pkg::CH_R);
   assign cls.is_c     = (data_byte == hwbt_pkg::CH_C);

endmodule

`default_nettype wire

### rtl/hwbt_fifo.sv
// ----------------------------------------------------------------------------
// hwbt_fifo - small synchronous FIFO
// Power-of-two depth, first-word fall-through read.
// ----------------------------------------------------------------------------
`default_nettype none

module hwbt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hwbt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [WIDTH-1:0]       rd_data,
   output logic                   empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### rtl/hwbt_scan.sv
// ----------------------------------------------------------------------------
// hwbt_scan - tokenizer back end
// Per-byte scan state: preamble search, words, tags, src value, events.
// ----------------------------------------------------------------------------
`default_nettype none

module hwbt_scan #(
   parameter int OFFSET_BITS = hwbt_pkg::OFFSET_BITS_DEF,
   parameter int NAME_BYTES  = hwbt_pkg::NAME_BYTES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      skip_preamble,
   input  wire logic                      item_valid,
   input  wire hwbt_pkg::byte_class_type  item,
   output logic                           item_pop,
   input  wire logic                      out_full,
   output logic                           ev_push,
   output hwbt_pkg::event_type            ev
);

   localparam int LEN_BITS = $clog2(NAME_BYTES + 1);
   localparam int IDX_BITS = $clog2(NAME_BYTES);
   localparam int PRE_NAME = 4;   // "html" after the '<'

   logic [OFFSET_BITS-1:0]   offset_ff, offset_in, off_next;
   logic [2:0]               pre_match_ff, pre_match_in;
   hwbt_pkg::scan_mode_type  mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]   word_begin_ff, word_begin_in;
   logic                     bold_ff, bold_in;
   logic                     italic_ff, italic_in;
   logic                     has_words_ff, has_words_in;
   logic [7:0]               name_ff [NAME_BYTES];
   logic [7:0]               name_in [NAME_BYTES];
   logic [LEN_BITS-1:0]      name_len_ff, name_len_in;
   hwbt_pkg::tag_flags_type  flags_ff, flags_in;
   hwbt_pkg::src_phase_type  src_phase_ff, src_phase_in;
   logic [OFFSET_BITS-1:0]   src_lo_ff, src_lo_in;
   logic [OFFSET_BITS-1:0]   src_hi_ff, src_hi_in;

   logic                     take;
   logic                     ev_valid;
   hwbt_pkg::event_kind_type ev_kind;
   logic [OFFSET_BITS-1:0]   ev_start_off, ev_end_off;
   logic                     ev_bold, ev_italic;

   // exact tag-name matches on the collected name
   logic name_ok, len1, len2, len3;
   logic is_head, is_blk, is_b, is_i, is_img, direct;

   assign name_ok = !flags_ff.too_long;
   assign len1    = name_ok && (name_len_ff == LEN_BITS'(1));
   assign len2    = name_ok && (name_len_ff == LEN_BITS'(2));
   assign len3    = name_ok && (name_len_ff == LEN_BITS'(3));
   assign is_head = len2 && (name_ff[0] == "h") && (name_ff[1] inside {["1":"4"]});
   assign is_blk  = (len1 && (name_ff[0] == "p")) ||
                    (len3 && (name_ff[0] == "d") && (name_ff[1] == "i") && (name_ff[2] == "v")) ||
                    (len2 && (name_ff[0] == "l") && (name_ff[1] == "i"));
   assign is_b    = len1 && (name_ff[0] == "b");
   assign is_i    = len1 && (name_ff[0] == "i");
   assign is_img  = len3 && (name_ff[0] == "i") && (name_ff[1] == "m") && (name_ff[2] == "g");
   assign direct  = !flags_ff.name_end;

   assign take     = item_valid && !out_full;
   assign item_pop = take;
   assign ev_push  = take && ev_valid;
   assign off_next = offset_ff + OFFSET_BITS'(1);

   always_comb begin
      offset_in     = offset_ff;
      pre_match_in  = pre_match_ff;
      mode_in       = mode_ff;
      word_begin_in = word_begin_ff;
      bold_in       = bold_ff;
      italic_in     = italic_ff;
      has_words_in  = has_words_ff;
      name_in       = name_ff;
      name_len_in   = name_len_ff;
      flags_in      = flags_ff;
      src_phase_in  = src_phase_ff;
      src_lo_in     = src_lo_ff;
      src_hi_in     = src_hi_ff;
      ev_valid      = 1'b0;
      ev_kind       = hwbt_pkg::KIND_WORD;
      ev_start_off  = '0;
      ev_end_off    = '0;
      ev_bold       = 1'b0;
      ev_italic     = 1'b0;

      if (take) begin
         if (skip_preamble && (pre_match_ff != hwbt_pkg::PRE_DONE)) begin
            if (item.data == hwbt_pkg::preamble_char(pre_match_ff)) begin
               pre_match_in = pre_match_ff + 3'd1;
            end else begin
               pre_match_in = item.is_lt ? 3'd1 : 3'd0;
            end
            if (pre_match_in == hwbt_pkg::PRE_DONE) begin
               // marker complete: behaves as an open tag holding "html"
               mode_in = hwbt_pkg::MODE_TAG;
               for (int k = 0; k < NAME_BYTES; k++) begin
                  if (k < PRE_NAME) begin
                     name_in[k] = hwbt_pkg::preamble_char(3'(k + 1));
                  end
               end
               name_len_in       = LEN_BITS'((NAME_BYTES < PRE_NAME) ? NAME_BYTES : PRE_NAME);
               flags_in          = '0;
               flags_in.too_long = (NAME_BYTES < PRE_NAME);
               src_phase_in      = hwbt_pkg::SRC_IDLE;
               if (item.last) begin
                  ev_valid     = 1'b1;
                  ev_kind      = hwbt_pkg::KIND_ERROR;
                  ev_start_off = offset_ff;
                  ev_end_off   = offset_ff;
               end
            end
         end else begin
            pre_match_in = hwbt_pkg::PRE_DONE;
            if (mode_ff == hwbt_pkg::MODE_TAG) begin
               if (item.is_gt) begin
                  mode_in = hwbt_pkg::MODE_GAP;
                  if (flags_ff.close) begin
                     if (is_head || is_blk) begin
                        if (is_head) begin
                           bold_in = 1'b0;
                        end
                        if (has_words_ff) begin
                           has_words_in = 1'b0;
                           ev_valid     = 1'b1;
                           ev_kind      = hwbt_pkg::KIND_BREAK;
                        end
                     end else begin
                        if (direct && is_b) begin
                           bold_in = 1'b0;
                        end
                        if (direct && is_i) begin
                           italic_in = 1'b0;
                        end
                     end
                  end else if (flags_ff.slash) begin
                     if (is_img && (src_phase_ff == hwbt_pkg::SRC_FOUND)) begin
                        has_words_in = 1'b0;
                        ev_valid     = 1'b1;
                        ev_kind      = hwbt_pkg::KIND_IMAGE;
                        ev_start_off = src_lo_ff;
                        ev_end_off   = src_hi_ff;
                     end
                  end else if (is_head || is_blk) begin
                     if (is_head) begin
                        bold_in = 1'b1;
                     end
                     if (has_words_ff) begin
                        has_words_in = 1'b0;
                        ev_valid     = 1'b1;
                        ev_kind      = hwbt_pkg::KIND_BREAK;
                     end
                  end else if (direct && is_b) begin
                     bold_in = 1'b1;
                  end else if (direct && is_i) begin
                     italic_in = 1'b1;
                  end
               end else begin
                  // tag body byte: name collection and src search
                  flags_in.first = 1'b0;
                  if (flags_ff.first && item.is_slash) begin
                     flags_in.close = 1'b1;
                  end else begin
                     if (item.is_slash) begin
                        flags_in.slash = 1'b1;
                     end
                     if (!flags_ff.name_end) begin
                        if (item.is_space) begin
                           flags_in.name_end = 1'b1;
                        end else if (name_len_ff < LEN_BITS'(NAME_BYTES)) begin
                           name_in[name_len_ff[IDX_BITS-1:0]] = item.data;
                           name_len_in = name_len_ff + LEN_BITS'(1);
                        end else begin
                           flags_in.too_long = 1'b1;
                        end
                     end
                  end
                  case (src_phase_ff)
                     hwbt_pkg::SRC_IDLE: begin
                        src_phase_in = item.is_s ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE;
                     end
                     hwbt_pkg::SRC_S: begin
                        src_phase_in = item.is_r ? hwbt_pkg::SRC_R :
                                       item.is_s ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE;
                     end
                     hwbt_pkg::SRC_R: begin
                        src_phase_in = item.is_c ? hwbt_pkg::SRC_C :
                                       item.is_s ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE;
                     end
                     hwbt_pkg::SRC_C: begin
                        if (!item.is_ws) begin
                           src_phase_in = hwbt_pkg::SRC_SEP;
                        end
                     end
                     hwbt_pkg::SRC_SEP: begin
                        if (!item.is_ws) begin
                           src_lo_in    = off_next;
                           src_phase_in = hwbt_pkg::SRC_VALUE;
                        end
                     end
                     hwbt_pkg::SRC_VALUE: begin
                        if (item.is_quote) begin
                           src_hi_in    = offset_ff;
                           src_phase_in = hwbt_pkg::SRC_FOUND;
                        end
                     end
                     default: begin
                        src_phase_in = src_phase_ff;
                     end
                  endcase
                  if (item.last) begin
                     ev_valid     = 1'b1;
                     ev_kind      = hwbt_pkg::KIND_ERROR;
                     ev_start_off = offset_ff;
                     ev_end_off   = offset_ff;
                  end
               end
            end else if (item.is_lt) begin
               if (item.last) begin
                  ev_valid     = 1'b1;
                  ev_kind      = hwbt_pkg::KIND_ERROR;
                  ev_start_off = offset_ff;
                  ev_end_off   = offset_ff;
               end else begin
                  if (mode_ff == hwbt_pkg::MODE_WORD) begin
                     has_words_in = 1'b1;
                     ev_valid     = 1'b1;
                     ev_kind      = hwbt_pkg::KIND_WORD;
                     ev_start_off = word_begin_ff;
                     ev_end_off   = offset_ff;
                     ev_bold      = bold_ff;
                     ev_italic    = italic_ff;
                  end
                  mode_in        = hwbt_pkg::MODE_TAG;
                  name_len_in    = '0;
                  flags_in       = '0;
                  flags_in.first = 1'b1;
                  src_phase_in   = hwbt_pkg::SRC_IDLE;
               end
            end else if (item.is_ws) begin
               if (mode_ff == hwbt_pkg::MODE_WORD) begin
                  has_words_in = 1'b1;
                  ev_valid     = 1'b1;
                  ev_kind      = hwbt_pkg::KIND_WORD;
                  ev_start_off = word_begin_ff;
                  ev_end_off   = offset_ff;
                  ev_bold      = bold_ff;
                  ev_italic    = italic_ff;
               end
               mode_in = hwbt_pkg::MODE_GAP;
            end else begin
               if (mode_ff != hwbt_pkg::MODE_WORD) begin
                  word_begin_in = offset_ff;
                  mode_in       = hwbt_pkg::MODE_WORD;
               end
               if (item.last) begin
                  has_words_in = 1'b1;
                  ev_valid     = 1'b1;
                  ev_kind      = hwbt_pkg::KIND_WORD;
                  ev_start_off = word_begin_in;
                  ev_end_off   = off_next;
                  ev_bold      = bold_ff;
                  ev_italic    = italic_ff;
               end
            end
         end

         // end of document: back to the initial scan state
         if (item.last) begin
            offset_in    = '0;
            pre_match_in = '0;
            mode_in      = hwbt_pkg::MODE_GAP;
            bold_in      = 1'b0;
            italic_in    = 1'b0;
            has_words_in = 1'b0;
            name_len_in  = '0;
            flags_in     = '0;
            src_phase_in = hwbt_pkg::SRC_IDLE;
         end else begin
            offset_in = off_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hwbt_pkg::MODE_GAP;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         pre_match_ff <= '0;
         bold_ff      <= 1'b0;
         italic_ff    <= 1'b0;
         has_words_ff <= 1'b0;
         name_len_ff  <= '0;
         flags_ff     <= '0;
         src_phase_ff <= hwbt_pkg::SRC_IDLE;
      end else begin
         offset_ff    <= offset_in;
         pre_match_ff <= pre_match_in;
         bold_ff      <= bold_in;
         italic_ff    <= italic_in;
         has_words_ff <= has_words_in;
         name_len_ff  <= name_len_in;
         flags_ff     <= flags_in;
         src_phase_ff <= src_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      word_begin_ff <= word_begin_in;
      src_lo_ff     <= src_lo_in;
      src_hi_ff     <= src_hi_in;
      name_ff       <= name_in;
   end

   assign ev.kind      = ev_kind;
   assign ev.bold_on   = ev_bold;
   assign ev.italic_on = ev_italic;

   if (OFFSET_BITS >= hwbt_pkg::SPAN_BITS) begin : g_span_cut
      assign ev.span_start = ev_start_off[hwbt_pkg::SPAN_BITS-1:0];
      assign ev.span_end   = ev_end_off[hwbt_pkg::SPAN_BITS-1:0];
   end else begin : g_span_ext
      assign ev.span_start = {{(hwbt_pkg::SPAN_BITS - OFFSET_BITS){1'b0}}, ev_start_off};
      assign ev.span_end   = {{(hwbt_pkg::SPAN_BITS - OFFSET_BITS){1'b0}}, ev_end_off};
   end

endmodule

`default_nettype wire

### rtl/html_word_block_tokenizer.sv
// ----------------------------------------------------------------------------
// html_word_block_tokenizer - HTML word and block tokenizer, one byte per cycle
// Path: a byte is registered in the byte queue and its event in the result queue.
// Throughput: 1 byte per cycle while bytes wait and the result queue has room.
// Reset: synchronous; clears both queues and scan state, skip_preamble to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module html_word_block_tokenizer #(
   parameter int OFFSET_BITS = hwbt_pkg::OFFSET_BITS_DEF,
   parameter int NAME_BYTES  = hwbt_pkg::NAME_BYTES_DEF,
   parameter int QUEUE_DEPTH = hwbt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // byte input, queue style
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,

   // event output, queue style
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_event_kind,
   output logic [23:0]      rsp_span_start,
   output logic [23:0]      rsp_span_end,
   output logic             rsp_bold_on,
   output logic             rsp_italic_on,

   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_skip_preamble
);

   // Front end: each byte transaction is classified and parked in a short
   // queue. Back end: the scanner drains that queue one byte per cycle while
   // the result queue has room, and writes at most one event per byte.
   // The two queues decouple the byte source and the event sink, so either
   // side can stall without stopping the other until a queue fills.

   hwbt_pkg::byte_class_type front_cls;
   hwbt_pkg::byte_class_type back_item;
   logic                     back_valid;
   logic                     back_pop;
   logic                     q_empty;
   hwbt_pkg::event_type      back_ev;
   logic                     back_push;
   logic                     out_full;
   hwbt_pkg::event_type      rsp_ev;

   logic                     skip_preamble_ff;

   // Single register, always ready; user must write only while idle, unchecked.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_preamble_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         skip_preamble_ff <= csr_skip_preamble;
      end
   end

   hwbt_classify u_classify (
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .cls       (front_cls)
   );

   // front-to-back byte queue
   hwbt_fifo #(
      .WIDTH ($bits(hwbt_pkg::byte_class_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_byte_q (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_cls),
      .full    (full),
      .pop     (back_pop),
      .rd_data (back_item),
      .empty   (q_empty)
   );

   assign back_valid = !q_empty;

   hwbt_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .NAME_BYTES  (NAME_BYTES)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .skip_preamble (skip_preamble_ff),
      .item_valid    (back_valid),
      .item          (back_item),
      .item_pop      (back_pop),
      .out_full      (out_full),
      .ev_push       (back_push),
      .ev            (back_ev)
   );

   // result queue; its head drives the rsp ports
   hwbt_fifo #(
      .WIDTH ($bits(hwbt_pkg::event_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_q (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_ev),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_ev),
      .empty   (empty)
   );

   assign rsp_event_kind = rsp_ev.kind;
   assign rsp_span_start = rsp_ev.span_start;
   assign rsp_span_end   = rsp_ev.span_end;
   assign rsp_bold_on    = rsp_ev.bold_on;
   assign rsp_italic_on  = rsp_ev.italic_on;

   // Scanner only consumes a byte when the result queue can take its event.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !out_full)
      else $error("event written into a full result queue");

   // Block breaks carry no span and no style flags.
   a_break_clean: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_event_kind == hwbt_pkg::KIND_BREAK)) |->
      (rsp_span_start == '0) && (rsp_span_end == '0) && !rsp_bold_on && !rsp_italic_on)
      else $error("block break transaction with nonzero fields");

   // Tag errors point at the last byte: start equals end.
   a_error_span: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_event_kind == hwbt_pkg::KIND_ERROR)) |->
      (rsp_span_start == rsp_span_end) && !rsp_bold_on && !rsp_italic_on)
      else $error("tag error transaction with uneven span");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

endmodule

`default_nettype wire

### sim/html_word_block_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// html_word_block_tokenizer_tb - self-checking bench for the HTML tokenizer
// Streams short HTML documents (directed, then random but mostly well formed)
// through the byte queue. Expected word, block, image and error events are
// predicted per accepted byte and checked against every popped event.
// ----------------------------------------------------------------------------
`default_nettype none

module html_word_block_tokenizer_tb;

   localparam int NAME_LEN   = hwbt_pkg::NAME_BYTES_DEF;
   localparam int CYCLE_CAP  = 400000;
   localparam int PHASES     = 8;
   localparam int PHASE_BYTES = 110;
   // the four blank characters, picked by byte lane
   localparam logic [31:0] BLANKS = {hwbt_pkg::CH_SPACE, hwbt_pkg::CH_TAB,
                                     hwbt_pkg::CH_LF, hwbt_pkg::CH_CR};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } doc_byte_type;

   // ---------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [23:0] rsp_span_start;
   logic [23:0] rsp_span_end;
   logic        rsp_bold_on;
   logic        rsp_italic_on;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_skip_preamble = 1'b1;

   html_word_block_tokenizer i_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_span_start    (rsp_span_start),
      .rsp_span_end      (rsp_span_end),
      .rsp_bold_on       (rsp_bold_on),
      .rsp_italic_on     (rsp_italic_on),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_skip_preamble (csr_skip_preamble)
   );

   initial forever #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench bookkeeping
   // ---------------------------------------------------------------------
   doc_byte_type        byte_queue[$];       // bytes waiting for the driver
   logic [7:0]          doc_buf[$];          // document under construction
   hwbt_pkg::event_type expected_events[$];  // predicted events, oldest first
   int                  mismatch_count = 0;
   int                  sent_total = 0;
   int                  cycle_count = 0;
   int                  send_hold = 0;
   int                  pop_hold = 0;
   bit                  quiet_tail = 1'b0;   // no idling on either side when set

   // ---------------------------------------------------------------------
   // Tokenizer predictor state
   // ---------------------------------------------------------------------
   string                   marker_text = "<html";
   logic                    skip_cfg;
   logic [23:0]             doc_pos;
   logic [2:0]              marker_hits;
   hwbt_pkg::scan_mode_type mode_now;
   logic [23:0]             word_from;
   logic                    bold_now;
   logic                    italic_now;
   logic                    words_in_block;
   logic [7:0]              name_buf [NAME_LEN];
   int                      name_count;
   hwbt_pkg::tag_flags_type tflags;
   hwbt_pkg::src_phase_type src_state;
   logic [23:0]             src_lo;
   logic [23:0]             src_hi;

   function automatic bit is_blank(input logic [7:0] b);
      return b == hwbt_pkg::CH_SPACE || b == hwbt_pkg::CH_TAB ||
             b == hwbt_pkg::CH_LF || b == hwbt_pkg::CH_CR;
   endfunction

   // everything but the register goes back to its idle value at end of document
   function automatic void reset_document();
      doc_pos        = '0;
      marker_hits    = '0;
      mode_now       = hwbt_pkg::MODE_GAP;
      word_from      = '0;
      bold_now       = 1'b0;
      italic_now     = 1'b0;
      words_in_block = 1'b0;
      foreach (name_buf[k]) name_buf[k] = 8'h00;
      name_count     = 0;
      tflags         = '0;
      src_state      = hwbt_pkg::SRC_IDLE;
      src_lo         = '0;
      src_hi         = '0;
   endfunction

   function automatic void enter_tag();
      mode_now   = hwbt_pkg::MODE_TAG;
      foreach (name_buf[k]) name_buf[k] = 8'h00;
      name_count = 0;
      tflags     = '0;
      tflags.first = 1'b1;
      src_state  = hwbt_pkg::SRC_IDLE;
   endfunction

   // one tag byte other than '>': name collection, flags, src value search
   function automatic void take_tag_char(input logic [7:0] b, input logic [23:0] o);
      logic was_first;
      was_first    = tflags.first;
      tflags.first = 1'b0;
      if (was_first && b == hwbt_pkg::CH_SLASH) begin
         tflags.close = 1'b1;
      end else begin
         if (b == hwbt_pkg::CH_SLASH) tflags.slash = 1'b1;
         if (!tflags.name_end) begin
            if (b == hwbt_pkg::CH_SPACE) tflags.name_end = 1'b1;
            else if (name_count < NAME_LEN) begin
               name_buf[name_count] = b;
               name_count++;
            end else tflags.too_long = 1'b1;
         end
      end
      case (src_state)
         hwbt_pkg::SRC_IDLE:
            src_state = (b == hwbt_pkg::CH_S) ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE;
         hwbt_pkg::SRC_S:
            src_state = (b == hwbt_pkg::CH_R) ? hwbt_pkg::SRC_R :
                        ((b == hwbt_pkg::CH_S) ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE);
         hwbt_pkg::SRC_R:
            src_state = (b == hwbt_pkg::CH_C) ? hwbt_pkg::SRC_C :
                        ((b == hwbt_pkg::CH_S) ? hwbt_pkg::SRC_S : hwbt_pkg::SRC_IDLE);
         hwbt_pkg::SRC_C:
            if (!is_blank(b)) src_state = hwbt_pkg::SRC_SEP;
         hwbt_pkg::SRC_SEP: begin
            if (!is_blank(b)) begin
               src_lo    = o + 24'd1;
               src_state = hwbt_pkg::SRC_VALUE;
            end
         end
         hwbt_pkg::SRC_VALUE: begin
            if (b == hwbt_pkg::CH_QUOTE) begin
               src_hi    = o;
               src_state = hwbt_pkg::SRC_FOUND;
            end
         end
         default: ;
      endcase
   endfunction

   // exact tag name compare; an overlong name matches nothing
   function automatic bit name_is(input string s);
      if (tflags.too_long || name_count != s.len()) return 1'b0;
      for (int k = 0; k < s.len(); k++)
         if (name_buf[k] != s[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit end_block(output hwbt_pkg::event_type ev);
      ev = '0;
      if (!words_in_block) return 1'b0;
      words_in_block = 1'b0;
      ev.kind = hwbt_pkg::KIND_BREAK;
      return 1'b1;
   endfunction

   function automatic hwbt_pkg::event_type make_word(input logic [23:0] stop);
      hwbt_pkg::event_type ev;
      words_in_block = 1'b1;
      ev = '0;
      ev.kind       = hwbt_pkg::KIND_WORD;
      ev.span_start = word_from;
      ev.span_end   = stop;
      ev.bold_on    = bold_now;
      ev.italic_on  = italic_now;
      return ev;
   endfunction

   function automatic hwbt_pkg::event_type tag_error(input logic [23:0] o);
      hwbt_pkg::event_type ev;
      ev = '0;
      ev.kind       = hwbt_pkg::KIND_ERROR;
      ev.span_start = o;
      ev.span_end   = o;
      return ev;
   endfunction

   // the '>' that closes a tag
   function automatic bit finish_tag(output hwbt_pkg::event_type ev);
      bit heading;
      bit blk;
      bit bare;
      heading = name_is("h1") || name_is("h2") || name_is("h3") || name_is("h4");
      blk     = name_is("p") || name_is("div") || name_is("li");
      bare    = !tflags.name_end;
      ev = '0;
      mode_now = hwbt_pkg::MODE_GAP;
      if (tflags.close) begin
         if (heading) begin
            bold_now = 1'b0;
            return end_block(ev);
         end
         if (blk) return end_block(ev);
         if (bare && name_is("b")) bold_now = 1'b0;
         if (bare && name_is("i")) italic_now = 1'b0;
         return 1'b0;
      end
      if (tflags.slash) begin
         // self-closing: only an img with a complete quoted src reports
         if (name_is("img") && src_state == hwbt_pkg::SRC_FOUND) begin
            words_in_block = 1'b0;
            ev.kind       = hwbt_pkg::KIND_IMAGE;
            ev.span_start = src_lo;
            ev.span_end   = src_hi;
            return 1'b1;
         end
         return 1'b0;
      end
      if (heading) begin
         bold_now = 1'b1;
         return end_block(ev);
      end
      if (blk) return end_block(ev);
      if (bare && name_is("b")) bold_now = 1'b1;
      else if (bare && name_is("i")) italic_now = 1'b1;
      return 1'b0;
   endfunction

   // advance the predictor by one accepted byte, queue any event it causes
   function automatic void take_byte(input logic [7:0] b, input logic last);
      logic [23:0]         o;
      hwbt_pkg::event_type ev;
      bit                  hit;
      o   = doc_pos;
      hit = 1'b0;
      ev  = '0;
      if (marker_hits < hwbt_pkg::PRE_DONE && skip_cfg) begin
         if (b == marker_text[marker_hits]) marker_hits++;
         else marker_hits = (b == hwbt_pkg::CH_LT) ? 3'd1 : 3'd0;
         if (marker_hits == hwbt_pkg::PRE_DONE) begin
            // the marker itself opens the html tag
            enter_tag();
            for (int k = 1; k < 5; k++) take_tag_char(marker_text[k], o);
            if (last) begin
               hit = 1'b1;
               ev  = tag_error(o);
            end
         end
      end else begin
         marker_hits = hwbt_pkg::PRE_DONE;
         if (mode_now == hwbt_pkg::MODE_TAG) begin
            if (b == hwbt_pkg::CH_GT) hit = finish_tag(ev);
            else begin
               take_tag_char(b, o);
               if (last) begin
                  hit = 1'b1;
                  ev  = tag_error(o);
               end
            end
         end else if (b == hwbt_pkg::CH_LT) begin
            if (last) begin
               hit = 1'b1;
               ev  = tag_error(o);
            end else begin
               if (mode_now == hwbt_pkg::MODE_WORD) begin
                  hit = 1'b1;
                  ev  = make_word(o);
               end
               enter_tag();
            end
         end else if (is_blank(b)) begin
            if (mode_now == hwbt_pkg::MODE_WORD) begin
               hit = 1'b1;
               ev  = make_word(o);
            end
            mode_now = hwbt_pkg::MODE_GAP;
         end else begin
            if (mode_now != hwbt_pkg::MODE_WORD) begin
               word_from = o;
               mode_now  = hwbt_pkg::MODE_WORD;
            end
            if (last) begin
               hit = 1'b1;
               ev  = make_word(o + 24'd1);
            end
         end
      end
      if (last) reset_document();
      else doc_pos = o + 24'd1;
      if (hit) expected_events.insert(expected_events.size(), ev);
   endfunction

   function automatic void check_field(input string field, input logic [23:0] exp_v,
                                       input logic [23:0] got);
      if (got !== exp_v) begin
         $error("%s: expected %0d, got %0d", field, exp_v, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: tracks register writes and byte transactions for the
   // predictor, and checks every event transaction against the oldest
   // expectation. Prediction happens here so that an expectation is always
   // queued before the event it describes can be checked.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      hwbt_pkg::event_type want;
      if (reset) begin
         skip_cfg = 1'b1;
         reset_document();
      end else begin
         if (csr_valid && csr_ready) skip_cfg = csr_skip_preamble;
         if (push && !full) take_byte(req_data_byte, req_last_byte);
         if (pop && !empty) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d start %0d end %0d",
                      rsp_event_kind, rsp_span_start, rsp_span_end);
               mismatch_count++;
            end else begin
               want = expected_events.pop_front();
               check_field("event_kind", want.kind, rsp_event_kind);
               check_field("span_start", want.span_start, rsp_span_start);
               check_field("span_end", want.span_end, rsp_span_end);
               check_field("bold_on", want.bold_on, rsp_bold_on);
               check_field("italic_on", want.italic_on, rsp_italic_on);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Byte driver: holds a byte until its transaction completes, then takes
   // the next from byte_queue, with random idle bursts between bytes.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      doc_byte_type nxt;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (send_hold > 0) begin
            send_hold--;
            push <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            send_hold = $urandom_range(0, 6);
            push <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            nxt = byte_queue.pop_front();
            push          <= 1'b1;
            req_data_byte <= nxt.data;
            req_last_byte <= nxt.last;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // event sink: pops freely apart from random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold--;
         pop <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         pop_hold = $urandom_range(0, 6);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Document construction
   // ---------------------------------------------------------------------
   task automatic add_char(input logic [7:0] b);
      doc_buf.insert(doc_buf.size(), b);
   endtask

   task automatic add_str(input string s);
      for (int k = 0; k < s.len(); k++) doc_buf.insert(doc_buf.size(), s[k]);
   endtask

   task automatic add_letters(input int lo, input int hi);
      repeat ($urandom_range(lo, hi))
         doc_buf.insert(doc_buf.size(), 8'($urandom_range(97, 122)));
   endtask

   // text word; now and then a raw byte, kept off blanks and '<'
   task automatic add_word();
      logic [7:0] c;
      repeat ($urandom_range(1, 6)) begin
         c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(97, 122));
         if (is_blank(c) || c == hwbt_pkg::CH_LT) c = 8'h41;
         doc_buf.insert(doc_buf.size(), c);
      end
   endtask

   // src attribute: plain, spaced, unterminated (runs into '>'), or decoy
   task automatic add_src();
      case ($urandom_range(0, 4))
         0, 1: begin
            add_str(" src=\"");
            add_letters(0, 5);
            add_char(hwbt_pkg::CH_QUOTE);
         end
         2: begin
            add_str(" src = \"");
            add_letters(0, 5);
            add_char(hwbt_pkg::CH_QUOTE);
         end
         3: begin
            add_str(" src=\"");
            add_letters(0, 5);
         end
         default: begin
            add_str(" ssrc='");
            add_letters(0, 3);
            add_str("'\"");
         end
      endcase
   endtask

   function automatic string pick_tag_name(input int n);
      case (n)
         0:       return "h1";
         1:       return "h2";
         2:       return "h3";
         3:       return "h4";
         4:       return "p";
         5:       return "div";
         6:       return "li";
         7:       return "b";
         8:       return "i";
         9:       return "img";
         10:      return "span";
         11:      return "strong";
         12:      return "hr";
         default: return "";
      endcase
   endfunction

   task automatic add_tag();
      string nm;
      nm = pick_tag_name($urandom_range(0, 13));
      add_char(hwbt_pkg::CH_LT);
      if ($urandom_range(0, 2) == 0) add_char(hwbt_pkg::CH_SLASH);
      add_str(nm);
      if (nm == "img" || $urandom_range(0, 7) == 0) add_src();
      else if ($urandom_range(0, 4) == 0) add_str(" class=\"k\"");
      if (nm == "img" ? $urandom_range(0, 4) != 0 : $urandom_range(0, 7) == 0) begin
         if ($urandom_range(0, 1) != 0) add_char(hwbt_pkg::CH_SPACE);
         add_char(hwbt_pkg::CH_SLASH);
      end
      add_char(hwbt_pkg::CH_GT);
   endtask

   // hand the built document to the driver, last flag on its final byte
   task automatic ship(input bit complete);
      foreach (doc_buf[k])
         byte_queue.insert(byte_queue.size(),
                           '{data: doc_buf[k],
                             last: complete && k == doc_buf.size() - 1});
      sent_total += doc_buf.size();
      doc_buf.delete();
   endtask

   // random document; with the preamble skip on, junk and then the marker
   // (now and then no marker at all); complete = end with a last byte
   task automatic gen_doc(input bit skip_on, input bit complete);
      if (skip_on) begin
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
               0:       add_word();
               1:       add_str("<ht");
               default: add_char(8'($urandom_range(0, 255)));
            endcase
         end
         if ($urandom_range(0, 9) != 0) begin
            add_str("<html");
            if ($urandom_range(0, 1) != 0) add_str(" lang=\"en\"");
            add_char(hwbt_pkg::CH_GT);
         end
      end
      repeat ($urandom_range(1, 14)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_word();
            4, 5:       add_char(BLANKS[8 * $urandom_range(0, 3) +: 8]);
            6, 7, 8:    add_tag();
            default:    add_char(8'($urandom_range(0, 255)));
         endcase
      end
      // endings that leave a tag open on the last byte
      if (complete) begin
         case ($urandom_range(0, 7))
            0:       add_char(hwbt_pkg::CH_LT);
            1:       add_str("<p cl");
            2:       add_str("<html");
            default: ;
         endcase
      end
      ship(complete);
   endtask

   // wait until every byte went in and every predicted event came out,
   // then give the pipeline time to settle before touching the register
   task automatic drain();
      do @(negedge clock);
      while (byte_queue.size() != 0 || push || expected_events.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_skip(input logic v);
      csr_valid         <= 1'b1;
      csr_skip_preamble <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic skip_val;
      int   goal;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // skip on out of reset: junk before the marker, top byte value, tab,
      // and a document whose last byte is a lone '<'
      add_str("q<html>");
      add_char(8'hFF);
      add_str("a\t<");
      ship(1'b1);
      drain();

      // skip off: zero byte, bold on/off, then a tag cut off at the end
      write_skip(1'b0);
      add_char(8'h00);
      add_str("<b>A</b><p a");
      ship(1'b1);
      drain();

      // random phases, register toggled between them; a phase may stop
      // mid-document so the next setting lands on a half-scanned document
      for (int ph = 0; ph < PHASES; ph++) begin
         skip_val = (ph == 0) ? 1'b1 : ((ph == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
         if (ph == PHASES - 1) quiet_tail = 1'b1;
         write_skip(skip_val);
         goal = sent_total + PHASE_BYTES;
         while (sent_total < goal) gen_doc(skip_val, 1'b1);
         if ($urandom_range(0, 2) == 0) gen_doc(skip_val, 1'b0);
         drain();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/hwbt_pkg.sv
rtl/hwbt_classify.sv
rtl/hwbt_fifo.sv
rtl/hwbt_scan.sv
rtl/html_word_block_tokenizer.sv
sim/html_word_block_tokenizer_tb.sv
